FILE: src/assert_macros.svh
// Shared assertion macros, clocked on clk and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/cfir_pkg.sv
package cfir_pkg;

  localparam int SAMP_W = 16;
  localparam int COEF_W = 16;
  localparam int IDX_W  = 6;
  localparam int OUT_W  = 38;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_LOAD   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic en;
  } mac_ctl_t;

endpackage

FILE: src/cfir_store.sv
module cfir_store import cfir_pkg::*; #(
  parameter int TAPS = 51,
  parameter int AW   = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     smp_wr_en,
  input  logic [AW-1:0]            smp_wr_addr,
  input  logic signed [SAMP_W-1:0] smp_wr_re,
  input  logic signed [SAMP_W-1:0] smp_wr_im,
  input  logic                     cf_wr_en,
  input  logic [AW-1:0]            cf_wr_addr,
  input  logic signed [COEF_W-1:0] cf_wr_data,
  input  logic                     rd_en,
  input  logic [AW-1:0]            cf_rd_addr,
  input  logic [AW-1:0]            smp_rd_addr,
  output logic                     rd_valid,
  output logic signed [COEF_W-1:0] rd_coef,
  output logic signed [SAMP_W-1:0] rd_re,
  output logic signed [SAMP_W-1:0] rd_im
);

  logic [2*SAMP_W-1:0] smp_mem [TAPS];
  logic [COEF_W-1:0]   cf_mem  [TAPS];
  logic [TAPS-1:0]     cf_vld_r;

  logic [2*SAMP_W-1:0] smp_q_r;
  logic [COEF_W-1:0]   cf_q_r;
  logic                cf_vld_q_r;
  logic                rd_valid_r;

  always_ff @(posedge clk) begin
    if (smp_wr_en) begin
      smp_mem[smp_wr_addr] <= {smp_wr_re, smp_wr_im};
    end
    if (rd_en) begin
      smp_q_r <= smp_mem[smp_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cf_wr_en) begin
      cf_mem[cf_wr_addr] <= cf_wr_data;
    end
    if (rd_en) begin
      cf_q_r     <= cf_mem[cf_rd_addr];
      cf_vld_q_r <= cf_vld_r[cf_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cf_vld_r   <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= rd_en;
      if (cf_wr_en) begin
        cf_vld_r[cf_wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_valid = rd_valid_r;
  assign rd_coef  = cf_vld_q_r ? signed'(cf_q_r) : '0;
  assign rd_re    = signed'(smp_q_r[2*SAMP_W-1:SAMP_W]);
  assign rd_im    = signed'(smp_q_r[SAMP_W-1:0]);

endmodule

FILE: src/cfir_mac.sv
module cfir_mac import cfir_pkg::*; #(
  parameter int ACC_W = 38
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mac_ctl_t                 ctl,
  input  logic signed [COEF_W-1:0] coef,
  input  logic signed [SAMP_W-1:0] re,
  input  logic signed [SAMP_W-1:0] im,
  output logic signed [OUT_W-1:0]  sum_re,
  output logic signed [OUT_W-1:0]  sum_im
);

  localparam int PROD_W = COEF_W + SAMP_W;
  localparam int SAT_W  = (ACC_W > OUT_W) ? ACC_W : OUT_W;

  logic signed [PROD_W-1:0] prod_re_r, prod_im_r;
  logic                     prod_v_r;
  logic signed [ACC_W-1:0]  acc_re_r, acc_im_r;
  logic signed [SAT_W-1:0]  ext_re, ext_im;

  always_ff @(posedge clk) begin
    prod_re_r <= PROD_W'(coef) * PROD_W'(re);
    prod_im_r <= PROD_W'(coef) * PROD_W'(im);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= ctl.en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (prod_v_r) begin
      acc_re_r <= acc_re_r + ACC_W'(prod_re_r);
      acc_im_r <= acc_im_r + ACC_W'(prod_im_r);
    end
  end

  always_comb begin
    ext_re = SAT_W'(acc_re_r);
    ext_im = SAT_W'(acc_im_r);
    if (ext_re > SAT_W'(OUT_MAX)) begin
      sum_re = OUT_MAX;
    end else if (ext_re < SAT_W'(OUT_MIN)) begin
      sum_re = OUT_MIN;
    end else begin
      sum_re = OUT_W'(ext_re);
    end
    if (ext_im > SAT_W'(OUT_MAX)) begin
      sum_im = OUT_MAX;
    end else if (ext_im < SAT_W'(OUT_MIN)) begin
      sum_im = OUT_MIN;
    end else begin
      sum_im = OUT_W'(ext_im);
    end
  end

endmodule

FILE: src/complex_fir_filter_unit.sv
// TAPS-tap FIR filter with real Q1.15 coefficients on complex I/Q samples.
// A load transaction (func = 1) writes one coefficient and leaves the input
// ready; indexes of TAPS or more are dropped. A sample transaction (func = 0)
// shifts the pair into a circular delay line; while the line is still filling
// it gives no result and leaves the input ready. Once TAPS samples are held,
// every sample transaction yields one full-precision I/Q result. The input
// stays busy while one multiply-accumulate pair per tap is issued through a
// single read port on each of the delay and coefficient memories, the read
// and product registers drain, and the result is loaded into the output
// register once it is free. A finished result waits there while the next
// transaction is taken. Reset clears the coefficients through per-entry
// valid bits; no clearing pass is needed.
`include "assert_macros.svh"

module complex_fir_filter_unit import cfir_pkg::*; #(
  parameter int TAPS = 51
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_func,
  input  logic signed [SAMP_W-1:0] in_sample_re,
  input  logic signed [SAMP_W-1:0] in_sample_im,
  input  logic [IDX_W-1:0]         in_tap_index,
  input  logic signed [COEF_W-1:0] in_tap_weight,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [OUT_W-1:0]  out_re,
  output logic signed [OUT_W-1:0]  out_im
);

  localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int FW    = $clog2(TAPS + 1);
  localparam int ACC_W = 32 + $clog2(TAPS);

  state_t state_r, state_nxt;

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0] iss_cnt_r, iss_cnt_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [1:0]    drain_r, drain_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0] out_re_r, out_im_r;

  logic in_acc, smp_acc, load_acc, run_acc, cf_in_range, out_load, rd_en;
  logic iss_last;
  mac_ctl_t mac_ctl;

  logic                     rd_valid;
  logic signed [COEF_W-1:0] rd_coef;
  logic signed [SAMP_W-1:0] rd_re, rd_im;
  logic signed [OUT_W-1:0]  sum_re, sum_im;

  assign in_acc      = in_valid && in_ready;
  assign smp_acc     = in_acc && (in_func == FUNC_SAMPLE);
  assign load_acc    = in_acc && (in_func == FUNC_LOAD);
  assign cf_in_range = {26'd0, in_tap_index} < 32'(TAPS);
  assign run_acc     = smp_acc && (fill_r >= FW'(TAPS - 1));
  assign iss_last    = iss_cnt_r == AW'(TAPS - 1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (run_acc) state_nxt = ST_ISSUE;
      ST_ISSUE: if (iss_last) state_nxt = ST_DRAIN;
      ST_DRAIN: if (drain_r == 2'd1) state_nxt = ST_DONE;
      ST_DONE:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ready = 1'b1;
      ST_ISSUE: rd_en = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  out_load = !out_valid_r || out_ready;
      default:  ;
    endcase
  end

  always_comb begin
    head_nxt    = head_r;
    rd_ptr_nxt  = rd_ptr_r;
    iss_cnt_nxt = iss_cnt_r;
    fill_nxt    = fill_r;
    drain_nxt   = drain_r;
    if (smp_acc) begin
      head_nxt    = (head_r == AW'(TAPS - 1)) ? '0 : head_r + 1'b1;
      rd_ptr_nxt  = head_r;
      iss_cnt_nxt = '0;
      drain_nxt   = '0;
      if (fill_r != FW'(TAPS)) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
    if (rd_en) begin
      rd_ptr_nxt  = (rd_ptr_r == '0) ? AW'(TAPS - 1) : rd_ptr_r - 1'b1;
      iss_cnt_nxt = iss_cnt_r + 1'b1;
    end
    if (state_r == ST_DRAIN) begin
      drain_nxt = drain_r + 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      rd_ptr_r    <= '0;
      iss_cnt_r   <= '0;
      fill_r      <= '0;
      drain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      iss_cnt_r   <= iss_cnt_nxt;
      fill_r      <= fill_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_re_r <= sum_re;
      out_im_r <= sum_im;
    end
  end

  assign mac_ctl.clear = run_acc;
  assign mac_ctl.en    = rd_valid;

  cfir_store #(
    .TAPS (TAPS),
    .AW   (AW)
  ) u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .smp_wr_en   (smp_acc),
    .smp_wr_addr (head_r),
    .smp_wr_re   (in_sample_re),
    .smp_wr_im   (in_sample_im),
    .cf_wr_en    (load_acc && cf_in_range),
    .cf_wr_addr  (AW'(in_tap_index)),
    .cf_wr_data  (in_tap_weight),
    .rd_en       (rd_en),
    .cf_rd_addr  (iss_cnt_r),
    .smp_rd_addr (rd_ptr_r),
    .rd_valid    (rd_valid),
    .rd_coef     (rd_coef),
    .rd_re       (rd_re),
    .rd_im       (rd_im)
  );

  cfir_mac #(
    .ACC_W (ACC_W)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .coef   (rd_coef),
    .re     (rd_re),
    .im     (rd_im),
    .sum_re (sum_re),
    .sum_im (sum_im)
  );

  assign out_valid = out_valid_r;
  assign out_re    = out_re_r;
  assign out_im    = out_im_r;

  `ASSERT_IMPL(a_no_mac_in_idle, state_r == ST_IDLE, !rd_valid)
  `ASSERT_CLK(a_fill_saturates, fill_r <= FW'(TAPS))
  `ASSERT_CLK(a_head_in_range, head_r <= AW'(TAPS - 1))
  `ASSERT_IMPL(a_issue_in_range, state_r == ST_ISSUE, iss_cnt_r <= AW'(TAPS - 1))
  `ASSERT_IMPL(a_load_only_done, out_load, state_r == ST_DONE && !rd_valid)

endmodule
